### src/mqsd_pkg.sv
// ----------------------------------------------------------------------------
// mqsd_pkg
// Shared types and constants of the multi quadrature step divider.
// ----------------------------------------------------------------------------
package mqsd_pkg;

  // fixed widths of the pin fields and the configuration port
  localparam int PIN_W       = 4;
  localparam int COUNT_W     = 3;
  localparam int TABLE_W     = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int WHICH_W     = 2;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ENCODER_COUNT = 2'd0,
    REG_LEFT_SKIP     = 2'd1,
    REG_RIGHT_SKIP    = 2'd2
  } cfg_reg_t;

  // outcome of the priority pick for one word
  typedef struct packed {
    logic       hit;
    logic       step_right;
    logic       step_left;
    logic [1:0] phase;
  } pick_t;

endpackage

### src/mqsd_pick.sv
// ----------------------------------------------------------------------------
// mqsd_pick
// Gray decode of every encoder, phase compare and lowest-index priority pick.
// ----------------------------------------------------------------------------
module mqsd_pick #(
  parameter int ENCODERS = 4,
  parameter int IDX_W    = 2
) (
  input  logic [mqsd_pkg::PIN_W-1:0]   clock_pins,
  input  logic [mqsd_pkg::PIN_W-1:0]   data_pins,
  input  logic [mqsd_pkg::COUNT_W-1:0] encoder_count,
  input  logic [ENCODERS-1:0][1:0]     last_phase,
  output logic [IDX_W-1:0]             idx,
  output mqsd_pkg::pick_t              pick
);
  import mqsd_pkg::*;

  logic [ENCODERS-1:0][1:0] phase_now;
  logic [ENCODERS-1:0]      changed;

  // per-encoder gray decode and compare
  for (genvar k = 0; k < ENCODERS; k++) begin : g_enc
    logic c;
    logic d;
    logic en;
    if (k < PIN_W) begin : g_pin
      assign c = clock_pins[k];
      assign d = data_pins[k];
    end else begin : g_nopin
      assign c = 1'b0;
      assign d = 1'b0;
    end
    assign en           = {1'b0, encoder_count} > 4'(k);
    assign phase_now[k] = {c, c ^ d};
    assign changed[k]   = en && (phase_now[k] != last_phase[k]);
  end

  // lowest changed encoder wins
  always_comb begin
    logic [1:0] diff;
    logic [1:0] old_phase;
    idx       = '0;
    pick      = '0;
    old_phase = '0;
    for (int k = ENCODERS - 1; k >= 0; k--) begin
      if (changed[k]) begin
        idx        = IDX_W'(k);
        pick.hit   = 1'b1;
        pick.phase = phase_now[k];
        old_phase  = last_phase[k];
      end
    end
    diff            = pick.phase - old_phase;
    pick.step_right = pick.hit && (diff == 2'd1);
    pick.step_left  = pick.hit && (diff == 2'd3);
  end

endmodule

### src/mqsd_counters.sv
// ----------------------------------------------------------------------------
// mqsd_counters
// Stored phases and per-direction step counters with the fire decision.
// ----------------------------------------------------------------------------
module mqsd_counters #(
  parameter int ENCODERS  = 4,
  parameter int SKIP_BITS = 8,
  parameter int IDX_W     = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         update,
  input  logic [IDX_W-1:0]             idx,
  input  mqsd_pkg::pick_t              pick,
  input  logic [mqsd_pkg::TABLE_W-1:0] left_skip_table,
  input  logic [mqsd_pkg::TABLE_W-1:0] right_skip_table,
  output logic [ENCODERS-1:0][1:0]     last_phase,
  output logic                         fired,
  output logic                         turn_right
);
  import mqsd_pkg::*;

  logic [ENCODERS-1:0][SKIP_BITS-1:0] left_count;
  logic [ENCODERS-1:0][SKIP_BITS-1:0] right_count;
  logic [ENCODERS-1:0]                left_full;
  logic [ENCODERS-1:0]                right_full;

  // skip fields and counter compares, one per encoder
  for (genvar k = 0; k < ENCODERS; k++) begin : g_enc
    localparam int POS = SKIP_BITS * k;
    logic [SKIP_BITS-1:0]         left_skip;
    logic [SKIP_BITS-1:0]         right_skip;
    logic [TABLE_W+SKIP_BITS-1:0] left_ext;
    logic [TABLE_W+SKIP_BITS-1:0] right_ext;
    assign left_ext  = {{SKIP_BITS{1'b0}}, left_skip_table};
    assign right_ext = {{SKIP_BITS{1'b0}}, right_skip_table};
    if (POS < TABLE_W) begin : g_field
      assign left_skip  = left_ext[POS +: SKIP_BITS];
      assign right_skip = right_ext[POS +: SKIP_BITS];
    end else begin : g_nofield
      assign left_skip  = '0;
      assign right_skip = '0;
    end
    assign left_full[k]  = left_count[k] >= left_skip;
    assign right_full[k] = right_count[k] >= right_skip;
  end

  // fire when the chosen direction's counter has reached its skip
  always_comb begin
    fired      = 1'b0;
    turn_right = 1'b0;
    if (pick.step_right && right_full[idx]) begin
      fired      = 1'b1;
      turn_right = 1'b1;
    end else if (pick.step_left && left_full[idx]) begin
      fired = 1'b1;
    end
  end

  // state update for the handled encoder
  always_ff @(posedge clk) begin
    if (rst) begin
      last_phase  <= '0;
      left_count  <= '0;
      right_count <= '0;
    end else if (update && pick.hit) begin
      last_phase[idx] <= pick.phase;
      if (pick.step_right) begin
        if (right_full[idx]) begin
          right_count[idx] <= '0;
        end else begin
          right_count[idx] <= right_count[idx] + 1'b1;
        end
      end
      if (pick.step_left) begin
        if (left_full[idx]) begin
          left_count[idx] <= '0;
        end else begin
          left_count[idx] <= left_count[idx] + 1'b1;
        end
      end
    end
  end

endmodule

### src/multi_quadrature_step_divider.sv
// ----------------------------------------------------------------------------
// multi_quadrature_step_divider
// Step divider for up to ENCODERS rotary encoders sampled together.
// ----------------------------------------------------------------------------
// Usage:
//   in channel   : in_valid / in_ready with clock_pins and data_pins, one word
//                  holding the sampled pin levels of every encoder.
//   out channel  : out_valid / out_ready with handled, which_encoder, fired
//                  and turn_right, exactly one word for each input word.
//   cfg channel  : cfg_valid / cfg_ready with cfg_index and cfg_data; index 0
//                  encoder count, 1 left skip table, 2 right skip table, any
//                  other index is dropped. Always ready; write only when idle.
// Timing:
//   a word lands in the input register, and the decode, priority pick and
//   counter update then run from it into the result register, which
//   presents the result. One word a cycle is taken sustained while out_ready
//   stays high; the limit is the single state update per cycle.
// Reset:
//   clears both pipeline stages, all stored phases and counters, sets the
//   encoder count to 1 and both skip tables to zero.
// Stall:
//   while out_ready is low the result holds, the input register keeps one
//   further word, and in_ready drops only when both are full.
// ----------------------------------------------------------------------------
module multi_quadrature_step_divider #(
  parameter int ENCODERS  = 4,
  parameter int SKIP_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mqsd_pkg::PIN_W-1:0]       clock_pins,
  input  logic [mqsd_pkg::PIN_W-1:0]       data_pins,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             handled,
  output logic [mqsd_pkg::WHICH_W-1:0]     which_encoder,
  output logic                             fired,
  output logic                             turn_right,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mqsd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mqsd_pkg::TABLE_W-1:0]     cfg_data
);
  import mqsd_pkg::*;

  localparam int IDX_W = (ENCODERS > 1) ? $clog2(ENCODERS) : 1;

  logic [COUNT_W-1:0]       encoder_count;
  logic [TABLE_W-1:0]       left_skip_table;
  logic [TABLE_W-1:0]       right_skip_table;

  logic                     in_full;
  logic [PIN_W-1:0]         in_clock;
  logic [PIN_W-1:0]         in_data;
  logic                     advance;

  logic [ENCODERS-1:0][1:0] last_phase;
  logic [IDX_W-1:0]         idx;
  pick_t                    pick;
  logic                     fire;
  logic                     fire_right;
  logic [IDX_W+1:0]         idx_ext;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      encoder_count    <= COUNT_W'(1);
      left_skip_table  <= '0;
      right_skip_table <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENCODER_COUNT: encoder_count    <= cfg_data[COUNT_W-1:0];
        REG_LEFT_SKIP:     left_skip_table  <= cfg_data;
        REG_RIGHT_SKIP:    right_skip_table <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign advance  = !out_valid || out_ready;
  assign in_ready = !in_full || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_clock <= clock_pins;
      in_data  <= data_pins;
    end
  end

  // decode and pick
  mqsd_pick #(
    .ENCODERS (ENCODERS),
    .IDX_W    (IDX_W)
  ) u_pick (
    .clock_pins    (in_clock),
    .data_pins     (in_data),
    .encoder_count (encoder_count),
    .last_phase    (last_phase),
    .idx           (idx),
    .pick          (pick)
  );

  // phase and counter state
  mqsd_counters #(
    .ENCODERS  (ENCODERS),
    .SKIP_BITS (SKIP_BITS),
    .IDX_W     (IDX_W)
  ) u_counters (
    .clk              (clk),
    .rst              (rst),
    .update           (in_full && advance),
    .idx              (idx),
    .pick             (pick),
    .left_skip_table  (left_skip_table),
    .right_skip_table (right_skip_table),
    .last_phase       (last_phase),
    .fired            (fire),
    .turn_right       (fire_right)
  );

  assign idx_ext = {2'b00, idx};

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_full) begin
      handled       <= pick.hit;
      which_encoder <= idx_ext[WHICH_W-1:0];
      fired         <= fire;
      turn_right    <= fire_right;
    end
  end

endmodule
